[rtl/sssb_pkg.sv]
// shared types, constants and glyph table for the seven-segment scan/blink core
// no dependencies
package sssb_pkg;

    // field widths
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned DELAY_W = 15;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned ANODE_W = 3;
    localparam int unsigned SEG_W   = 8;
    localparam int unsigned POS_W   = 2;
    localparam int unsigned MOD_W   = 10;   // value mod 1000
    localparam int unsigned DIGIT_W = 4;

    // stream packing
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 16;

    // register reset values
    localparam logic [DELAY_W-1:0] DELAY_RESET = 15'd250;

    // digit positions
    localparam logic [POS_W-1:0] POS_FIRST = 2'd0;
    localparam logic [POS_W-1:0] POS_MID   = 2'd1;
    localparam logic [POS_W-1:0] POS_LAST  = 2'd2;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_BLINK_DELAY  = 1'b0,
        CFG_BLINK_ENABLE = 1'b1
    } t_cfg_idx;

    // display modes, codes five to seven show dashes
    typedef enum logic [MODE_W-1:0] {
        MODE_NUMBER = 3'd0,
        MODE_OFF    = 3'd1,
        MODE_SLEEP  = 3'd2,
        MODE_ERROR  = 3'd3,
        MODE_DASHES = 3'd4
    } t_mode;

    // character codes, bit order f a g c b h d e, active high
    localparam logic [SEG_W-1:0] CH_F    = 8'hE1;
    localparam logic [SEG_W-1:0] CH_L    = 8'h83;
    localparam logic [SEG_W-1:0] CH_P    = 8'hE9;
    localparam logic [SEG_W-1:0] CH_E    = 8'hE3;
    localparam logic [SEG_W-1:0] CH_DASH = 8'h20;
    localparam logic [SEG_W-1:0] CH_DOT  = 8'h04;

    // request to the glyph encoder
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        logic              heat;
    } t_glyph_req;

    // decimal digit to character code
    function automatic logic [SEG_W-1:0] digit_code(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] c;
        case (d)
            4'd0: c = 8'hDB;
            4'd1: c = 8'h18;
            4'd2: c = 8'h6B;
            4'd3: c = 8'h7A;
            4'd4: c = 8'hB8;
            4'd5: c = 8'hF2;
            4'd6: c = 8'hF3;
            4'd7: c = 8'h58;
            4'd8: c = 8'hFB;
            4'd9: c = 8'hFA;
            default: c = 8'hDB;
        endcase
        return c;
    endfunction

endpackage

[rtl/sssb_glyph.sv]
// glyph encoder: splits a value below 1000 into digits and picks one character
// depends on sssb_pkg
module sssb_glyph (
    input  sssb_pkg::t_glyph_req             i_req,
    input  logic [sssb_pkg::MOD_W-1:0]       i_mod_value,
    output logic [sssb_pkg::SEG_W-1:0]       o_segments
);

    logic [15:0]                     hund_prod;
    logic [sssb_pkg::DIGIT_W-1:0]    hund;
    logic [6:0]                      rem;
    logic [14:0]                     tens_prod;
    logic [sssb_pkg::DIGIT_W-1:0]    tens;
    logic [sssb_pkg::DIGIT_W-1:0]    ones;
    logic [sssb_pkg::DIGIT_W-1:0]    digit;
    logic [sssb_pkg::SEG_W-1:0]      code;
    logic [sssb_pkg::SEG_W-1:0]      code_dot;

    // hundreds by reciprocal, x*41 >> 12 is exact below 1000
    assign hund_prod = 16'(i_mod_value) * 16'd41;
    assign hund      = hund_prod[15:12];
    assign rem       = 7'(i_mod_value - (10'(hund) * 10'd100));

    // tens by reciprocal, r*205 >> 11 is exact below 100
    assign tens_prod = 15'(rem) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones      = 4'(rem - (7'(tens) * 7'd10));

    // digit for this position
    always_comb begin
        case (i_req.pos)
            sssb_pkg::POS_FIRST: digit = hund;
            sssb_pkg::POS_MID:   digit = tens;
            default:             digit = ones;
        endcase
    end

    // character per mode and position
    always_comb begin
        case (i_req.mode)
            sssb_pkg::MODE_NUMBER: code = sssb_pkg::digit_code(digit);
            sssb_pkg::MODE_OFF: begin
                code = (i_req.pos == sssb_pkg::POS_FIRST) ? sssb_pkg::digit_code(4'd0)
                                                          : sssb_pkg::CH_F;
            end
            sssb_pkg::MODE_SLEEP: begin
                case (i_req.pos)
                    sssb_pkg::POS_FIRST: code = sssb_pkg::digit_code(4'd5);
                    sssb_pkg::POS_MID:   code = sssb_pkg::CH_L;
                    default:             code = sssb_pkg::CH_P;
                endcase
            end
            sssb_pkg::MODE_ERROR: begin
                case (i_req.pos)
                    sssb_pkg::POS_FIRST: code = sssb_pkg::digit_code(4'd5);
                    sssb_pkg::POS_MID:   code = sssb_pkg::CH_DASH;
                    default:             code = sssb_pkg::CH_E;
                endcase
            end
            default: code = sssb_pkg::CH_DASH;
        endcase
    end

    // heater dot on the last digit, lines are active low
    assign code_dot   = (i_req.heat && i_req.pos == sssb_pkg::POS_LAST)
                        ? (code | sssb_pkg::CH_DOT) : code;
    assign o_segments = ~code_dot;

endmodule

[rtl/seven_segment_scan_blink_core.sv]
// top level of the three-digit seven-segment scan driver with blink
// depends on sssb_pkg and sssb_glyph
//
// channel  direction  handshake                      payload
// s_axis   in         s_axis_tvalid/s_axis_tready    tdata: value, heater; tuser: mode
// m_axis   out        m_axis_tvalid/m_axis_tready    tdata: anodes, segments
// cfg      in         i_cfg_valid/o_cfg_ready        index, data (always ready)
//
// one item per cycle sustained while m_axis_tready stays high; the result leaves from the stage c register
// stage a: blink counter and scan index, stage b: value mod 1000,
// stage c: digit split and glyph lookup into the output register
// each stage loads when empty or when the next one loads, so bubbles absorb stalls
// synchronous active-low reset clears counters and the held segments, delay goes to 250
module seven_segment_scan_blink_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] shown_value, [16] heater_on, rest zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] display_mode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] anodes, [10:3] segments, rest zero
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    localparam int unsigned MW = sssb_pkg::MODE_W;
    localparam int unsigned PW = sssb_pkg::POS_W;
    localparam int unsigned CW = sssb_pkg::COUNT_W;
    localparam int unsigned SW = sssb_pkg::SEG_W;
    localparam int unsigned AW = sssb_pkg::ANODE_W;

    // configuration registers
    logic [sssb_pkg::DELAY_W-1:0] r_delay;
    logic                         r_blink_en;

    // control state
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_scan,  n_scan;
    logic [SW-1:0] r_held,  n_held;

    // stage a
    logic                          r_a_valid;
    logic [MW-1:0]                 r_a_mode;
    logic [sssb_pkg::VALUE_W-1:0]  r_a_value;
    logic                          r_a_heat;
    logic [PW-1:0]                 r_a_pos;
    logic                          r_a_blank;

    // stage b
    logic                          r_b_valid;
    logic [MW-1:0]                 r_b_mode;
    logic [sssb_pkg::MOD_W-1:0]    r_b_x;
    logic                          r_b_heat;
    logic [PW-1:0]                 r_b_pos;
    logic                          r_b_blank;

    // stage c, output register
    logic          r_c_valid;
    logic [AW-1:0] r_c_anodes;
    logic [SW-1:0] r_c_segs;

    logic          c_ready, b_ready, a_ready, in_acc;
    logic [CW-1:0] dbl_delay, cnt_base, cnt_inc;
    logic          blank;
    logic [PW-1:0] pos;
    logic [11:0]   fold, fold1;
    logic [sssb_pkg::MOD_W-1:0] mod_x;
    sssb_pkg::t_glyph_req       glyph_req;
    logic [SW-1:0] glyph_segs;
    logic [AW-1:0] anode_hot;

    // stage handshakes
    assign c_ready       = !r_c_valid || m_axis_tready;
    assign b_ready       = !r_b_valid || c_ready;
    assign a_ready       = !r_a_valid || b_ready;
    assign s_axis_tready = a_ready;
    assign in_acc        = s_axis_tvalid && a_ready;
    assign o_cfg_ready   = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay    <= sssb_pkg::DELAY_RESET;
            r_blink_en <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sssb_pkg::CFG_BLINK_DELAY:  r_delay    <= i_cfg_data;
                sssb_pkg::CFG_BLINK_ENABLE: r_blink_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // blink phase and scan position for the incoming item
    assign dbl_delay = {r_delay, 1'b0};
    assign cnt_base  = (!r_blink_en || r_count >= dbl_delay) ? '0 : r_count;
    assign cnt_inc   = cnt_base + CW'(1);
    assign blank     = cnt_inc > CW'(r_delay);
    assign pos       = (r_scan > sssb_pkg::POS_LAST) ? sssb_pkg::POS_FIRST : r_scan;

    always_comb begin
        n_count = r_count;
        n_scan  = r_scan;
        if (in_acc) begin
            n_count = cnt_inc;
            if (!blank) begin
                n_scan = (pos >= sssb_pkg::POS_LAST) ? sssb_pkg::POS_FIRST : pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_scan  <= sssb_pkg::POS_FIRST;
        end else begin
            r_count <= n_count;
            r_scan  <= n_scan;
        end
    end

    // stage a register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_mode  <= s_axis_tuser;
            r_a_value <= s_axis_tdata[15:0];
            r_a_heat  <= s_axis_tdata[16];
            r_a_pos   <= pos;
            r_a_blank <= blank;
        end
    end

    // value mod 1000: 1024 folds to 24, then at most two subtractions
    assign fold  = 12'(r_a_value[9:0]) + (12'(r_a_value[15:10]) << 4)
                 + (12'(r_a_value[15:10]) << 3);
    assign fold1 = (fold >= 12'd1000) ? fold - 12'd1000 : fold;
    assign mod_x = (fold1 >= 12'd1000) ? 10'(fold1 - 12'd1000) : 10'(fold1);

    // stage b register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_mode  <= r_a_mode;
            r_b_x     <= mod_x;
            r_b_heat  <= r_a_heat;
            r_b_pos   <= r_a_pos;
            r_b_blank <= r_a_blank;
        end
    end

    // glyph lookup
    assign glyph_req.mode = r_b_mode;
    assign glyph_req.pos  = r_b_pos;
    assign glyph_req.heat = r_b_heat;

    sssb_glyph u_glyph (
        .i_req       (glyph_req),
        .i_mod_value (r_b_x),
        .o_segments  (glyph_segs)
    );

    always_comb begin
        case (r_b_pos)
            sssb_pkg::POS_FIRST: anode_hot = 3'b001;
            sssb_pkg::POS_MID:   anode_hot = 3'b010;
            default:             anode_hot = 3'b100;
        endcase
    end

    // held segments follow each shown item, blanked items repeat them
    always_comb begin
        n_held = r_held;
        if (c_ready && r_b_valid && !r_b_blank) begin
            n_held = glyph_segs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_c_valid <= 1'b0;
        end else begin
            r_held <= n_held;
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // stage c, output register
    always_ff @(posedge i_clk) begin
        if (c_ready && r_b_valid) begin
            r_c_anodes <= r_b_blank ? '0 : anode_hot;
            r_c_segs   <= n_held;
        end
    end

    assign m_axis_tvalid = r_c_valid;
    assign m_axis_tdata  = {5'b0, r_c_segs, r_c_anodes};

`ifndef SYNTHESIS
    // at most one digit enabled on a result
    a_anode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[2:0]))
        else $error("anodes not one-hot");

    // result segments always match the held copy
    a_held_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:3] == r_held))
        else $error("segments differ from held value");

    // scan index stays within the three digits
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan != 2'd3)
        else $error("scan index out of range");

    // scan moves only on an accepted item
    a_scan_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_scan) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("scan advanced without an item");
`endif

endmodule
